// ===== design/itdp_pkg.sv =====
// Shared types and constants for the int8 tile dot-product matrix multiply unit.
package itdp_pkg;

	localparam int TileRows  = 8;
	localparam int TileBytes = 32;
	localparam int Group     = 4;
	localparam int OutCols   = TileBytes / Group;
	localparam int NumCells  = 4;
	localparam int Steps     = TileBytes / NumCells;
	localparam int SumW      = 21;
	localparam int ProdW     = 16;
	localparam int RowW      = 3;
	localparam int ColW      = 5;
	localparam int AddrW     = 8;
	localparam int StepW     = 3;
	localparam int NIdxW     = 3;
	localparam int BankDepth = TileRows * TileBytes / NumCells;
	localparam int BankAW    = $clog2(BankDepth);

	typedef enum logic [1:0] {
		OP_WR_A    = 2'd0,
		OP_WR_B    = 2'd1,
		OP_COMPUTE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// Control token that rides alongside the data through the cell chain.
	typedef struct packed {
		logic             vld;
		logic             first;
		logic             done;
		logic [RowW-1:0]  m;
		logic [NIdxW-1:0] n;
		logic             last;
	} tag_t;

endpackage

// ===== design/itdp_cell.sv =====
// One multiply-accumulate cell of the dot-product chain.
module itdp_cell (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [7:0]                a_byte,
	input  logic signed [7:0]                b_byte,
	input  logic signed [itdp_pkg::SumW-1:0] sum_in,
	output logic signed [itdp_pkg::SumW-1:0] sum_out
);
	import itdp_pkg::*;

	logic signed [ProdW-1:0] prod;

	assign prod = a_byte * b_byte;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_out <= sum_in + SumW'(prod);
		end
	end

endmodule

// ===== design/itdp_tile_mem.sv =====
// Byte tile memory with one write port and one registered read port.
module itdp_tile_mem (
	input  logic                        clk,
	input  logic                        we,
	input  logic [itdp_pkg::BankAW-1:0] waddr,
	input  logic [7:0]                  wdata,
	input  logic                        re,
	input  logic [itdp_pkg::BankAW-1:0] raddr,
	output logic [7:0]                  rdata
);
	import itdp_pkg::*;

	logic [7:0] mem_q [BankDepth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/int8_tile_dot_product_matmul_unit.sv =====
// Top level of the int8 tile dot-product matrix multiply unit.
// Usage: requests arrive on in_valid/in_stall with op, tile_row, tile_col
// and byte_value. Op 0 and 1 store one signed byte into the A or B tile
// and give no result; op 3 is dropped.
// Op 2 computes the 8x8 product and sends 64 results on out_valid/out_stall
// in row-major order, with last set on the final one.
// Each result needs 32 products; a chain of four MAC cells fed by four
// memory banks per tile handles four bytes a cycle while the pipe
// advances. in_stall stays high until the last step of a compute is
// issued, so no new request is taken before then; the last results
// drain after it drops. Results pass a two-entry output queue;
// when the receiver stalls and the queue is full, the chain freezes in
// place and nothing is lost.
// Reset clears the control state only; tile contents are undefined until
// written and must be loaded before a compute reads them.
module int8_tile_dot_product_matmul_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [2:0]        tile_row,
	input  logic [4:0]        tile_col,
	input  logic signed [7:0] byte_value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        out_row,
	output logic [2:0]        out_col,
	output logic signed [20:0] dot_sum,
	output logic              last
);
	import itdp_pkg::*;

	logic busy_q;
	logic [RowW-1:0]  m_q;
	logic [NIdxW-1:0] n_q;
	logic [StepW-1:0] k_q;
	logic issue;
	logic adv;
	logic acc_in;
	logic wr_a, wr_b;

	// Output queue, two entries.
	logic [1:0] cnt_q;
	logic       rp_q, wp_q;
	logic [RowW-1:0]  qm_q [2];
	logic [NIdxW-1:0] qn_q [2];
	logic [SumW-1:0]  qs_q [2];
	logic             ql_q [2];
	logic push, pop;

	tag_t tag_s1, tag_s2;
	tag_t tag_c [NumCells+1];
	logic signed [SumW-1:0] sum_c [NumCells+1];
	logic signed [7:0] a_rd [NumCells];
	logic signed [7:0] b_rd [NumCells];
	logic signed [7:0] a_dly [NumCells][NumCells];
	logic signed [7:0] b_dly [NumCells][NumCells];
	logic signed [SumW-1:0] acc_q;

	assign acc_in = in_valid && !in_stall;
	assign in_stall = busy_q;
	assign wr_a = acc_in && (op_t'(op) == OP_WR_A);
	assign wr_b = acc_in && (op_t'(op) == OP_WR_B);

	// The pipe advances whenever the queue has room for one more result.
	assign adv = (cnt_q != 2'd2) || pop;
	assign issue = busy_q && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			m_q <= '0;
			n_q <= '0;
			k_q <= '0;
		end else if (acc_in && op_t'(op) == OP_COMPUTE) begin
			busy_q <= 1'b1;
			m_q <= '0;
			n_q <= '0;
			k_q <= '0;
		end else if (issue) begin
			k_q <= k_q + 1'b1;
			if (k_q == StepW'(Steps-1)) begin
				n_q <= n_q + 1'b1;
				if (n_q == NIdxW'(OutCols-1)) begin
					m_q <= m_q + 1'b1;
					if (m_q == RowW'(TileRows-1)) begin
						busy_q <= 1'b0;
					end
				end
			end
		end
	end

	// Bank j holds byte columns with col%4 == j. A step k reads A[m][4k+j]
	// and B[k][4n+j], one byte per bank. Reads happen only when the pipe
	// advances, so a stall leaves rdata stable.
	for (genvar j = 0; j < NumCells; j++) begin : g_bank
		logic [BankAW-1:0] a_ra, b_ra;
		assign a_ra = {m_q, k_q};
		assign b_ra = {RowW'(k_q), n_q};
		itdp_tile_mem u_a (
			.clk  (clk),
			.we   (wr_a && tile_col[1:0] == 2'(j)),
			.waddr({tile_row, tile_col[4:2]}),
			.wdata(byte_value),
			.re   (adv),
			.raddr(a_ra),
			.rdata(a_rd[j])
		);
		itdp_tile_mem u_b (
			.clk  (clk),
			.we   (wr_b && tile_col[1:0] == 2'(j)),
			.waddr({tile_row, tile_col[4:2]}),
			.wdata(byte_value),
			.re   (adv),
			.raddr(b_ra),
			.rdata(b_rd[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1.vld   <= issue;
			tag_s1.first <= (k_q == '0);
			tag_s1.done  <= (k_q == StepW'(Steps-1));
			tag_s1.m     <= m_q;
			tag_s1.n     <= n_q;
			tag_s1.last  <= (m_q == RowW'(TileRows-1)) && (n_q == NIdxW'(OutCols-1));
		end
	end

	// Skew the bytes through a chain of delay registers so each cell sees its operands in step with its partial sum.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < NumCells; j++) begin
				a_dly[j][0] <= a_rd[j];
				b_dly[j][0] <= b_rd[j];
				for (int d = 1; d < NumCells; d++) begin
					a_dly[j][d] <= a_dly[j][d-1];
					b_dly[j][d] <= b_dly[j][d-1];
				end
			end
		end
	end

	assign tag_c[0] = tag_s1;
	assign sum_c[0] = '0;

	for (genvar j = 0; j < NumCells; j++) begin : g_chain
		logic signed [7:0] a_op, b_op;
		tag_t tq;
		if (j == 0) begin : g_head
			assign a_op = a_rd[j];
			assign b_op = b_rd[j];
		end else begin : g_tail
			assign a_op = a_dly[j][j-1];
			assign b_op = b_dly[j][j-1];
		end
		itdp_cell u_cell (
			.clk    (clk),
			.en     (adv),
			.a_byte (a_op),
			.b_byte (b_op),
			.sum_in (sum_c[j]),
			.sum_out(sum_c[j+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tq <= '0;
			end else if (adv) begin
				tq <= tag_c[j];
			end
		end
		assign tag_c[j+1] = tq;
	end

	// Accumulate the per-step partial sums into one result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (adv) begin
			tag_s2.vld   <= tag_c[NumCells].vld && tag_c[NumCells].done;
			tag_s2.first <= tag_c[NumCells].first;
			tag_s2.done  <= tag_c[NumCells].done;
			tag_s2.m     <= tag_c[NumCells].m;
			tag_s2.n     <= tag_c[NumCells].n;
			tag_s2.last  <= tag_c[NumCells].last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tag_c[NumCells].vld) begin
			acc_q <= (tag_c[NumCells].first ? '0 : acc_q) + sum_c[NumCells];
		end
	end

	assign push = adv && tag_s2.vld;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rp_q <= 1'b0;
			wp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			qm_q[wp_q] <= tag_s2.m;
			qn_q[wp_q] <= tag_s2.n;
			qs_q[wp_q] <= acc_q;
			ql_q[wp_q] <= tag_s2.last;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out_row = qm_q[rp_q];
	assign out_col = qn_q[rp_q];
	assign dot_sum = qs_q[rp_q];
	assign last    = ql_q[rp_q];

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |-> !push)
		else $error("push into full queue");
	a_idle_no_issue: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !issue)
		else $error("issue while idle");

endmodule
